>>> hdl/crcfss_pkg.sv
// Package for the CRC-32 framed two-wire serial sender.
// Holds frame constants, register codes, the microcode table and the CRC byte update.
// Depends on nothing; every other file in hdl uses it.
`timescale 1ns / 1ps

package crcfss_pkg;

  localparam int unsigned MaxPayloadDefault = 255;
  localparam int unsigned RegW = 20;
  localparam int unsigned WaitW = 21;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumRegs = 5;

  localparam logic [7:0]  StartByte     = 8'hAE;
  localparam logic [8:0]  HeaderBytes   = 9'd6;
  localparam logic [4:0]  LastPhase     = 5'd17;
  localparam logic [4:0]  PhasesPerByte = 5'd18;
  localparam logic [31:0] CrcPoly       = 32'hEDB88320;
  localparam logic [31:0] CrcInit       = 32'hFFFFFFFF;

  localparam logic [CfgIdxW-1:0] RegSyncHigh   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSyncGap    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBitLead    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDataToClk  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegByteGap    = 3'd4;

  localparam logic [RegW-1:0] SyncHighReset  = 20'd1000;
  localparam logic [RegW-1:0] SyncGapReset   = 20'd100000;
  localparam logic [RegW-1:0] BitLeadReset   = 20'd4000;
  localparam logic [RegW-1:0] DataToClkReset = 20'd1000;
  localparam logic [RegW-1:0] ByteGapReset   = 20'd10000;

  localparam logic [1:0] CmdLoad    = 2'd0;
  localparam logic [1:0] CmdStart   = 2'd1;
  localparam logic [1:0] CmdAdvance = 2'd2;

  typedef logic [2:0] step_t;
  localparam step_t StepIdle  = 3'd0;
  localparam step_t StepLoad  = 3'd1;
  localparam step_t StepStart = 3'd2;
  localparam step_t StepEmit  = 3'd3;
  localparam step_t StepFetch = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_START = 3'd2,
    OP_EMIT  = 3'd3,
    OP_FETCH = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_DISPATCH = 2'd1,
    JMP_FETCH    = 2'd2
  } jmp_e;

  typedef struct packed {
    op_e   op;
    jmp_e  jmp;
    step_t next;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic accept;
  } ctrl_t;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      StepIdle:  w = '{op: OP_NONE,  jmp: JMP_DISPATCH, next: StepIdle};
      StepLoad:  w = '{op: OP_LOAD,  jmp: JMP_NEXT,     next: StepIdle};
      StepStart: w = '{op: OP_START, jmp: JMP_NEXT,     next: StepIdle};
      StepEmit:  w = '{op: OP_EMIT,  jmp: JMP_FETCH,    next: StepFetch};
      StepFetch: w = '{op: OP_FETCH, jmp: JMP_NEXT,     next: StepIdle};
      default:   w = '{op: OP_NONE,  jmp: JMP_NEXT,     next: StepIdle};
    endcase
    return w;
  endfunction

  function automatic logic [31:0] crc_add_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/crcfss_seq.sv
// Microcode sequencer of the serial sender: step counter, control store lookup and jumps.
// Depends on crcfss_pkg for the step codes, the control word and the microcode table.
`timescale 1ns / 1ps

module crcfss_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           command_i,
  input  logic                 need_fetch_i,
  output logic                 busy_o,
  output crcfss_pkg::ctrl_t    ctrl_o
);

  crcfss_pkg::step_t  step_q, step_d;
  crcfss_pkg::uword_t uw;
  logic               accept;

  assign uw     = crcfss_pkg::ucode(step_q);
  assign busy_o = (step_q != crcfss_pkg::StepIdle);
  assign accept = start_i && (step_q == crcfss_pkg::StepIdle);

  assign ctrl_o.op     = uw.op;
  assign ctrl_o.accept = accept;

  always_comb begin
    step_d = crcfss_pkg::StepIdle;
    unique case (uw.jmp)
      crcfss_pkg::JMP_NEXT: begin
        step_d = uw.next;
      end
      crcfss_pkg::JMP_DISPATCH: begin
        if (accept) begin
          unique case (command_i)
            crcfss_pkg::CmdLoad:    step_d = crcfss_pkg::StepLoad;
            crcfss_pkg::CmdStart:   step_d = crcfss_pkg::StepStart;
            crcfss_pkg::CmdAdvance: step_d = crcfss_pkg::StepEmit;
            default:                step_d = crcfss_pkg::StepIdle;
          endcase
        end else begin
          step_d = uw.next;
        end
      end
      crcfss_pkg::JMP_FETCH: begin
        step_d = need_fetch_i ? uw.next : crcfss_pkg::StepIdle;
      end
      default: begin
        step_d = crcfss_pkg::StepIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= crcfss_pkg::StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> hdl/crc_framed_clocked_serial_sender_top.sv
// Top level of the CRC-32 framed two-wire serial sender: datapath, payload memory, registers.
// Depends on crcfss_pkg and on crcfss_seq, which runs the microcode.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low. A load or start command runs its own
// microcode step and then returns to idle; an advance runs the emit step, followed at the first
// write of each frame byte by a fetch step that takes the byte from the registered read port of
// the payload memory. Each advance made while a frame is playing gives one pin write on the
// result ports for exactly one cycle, marked by strobe_o, in the cycle after its emit step;
// the receiver must take every beat as it comes. Configuration writes are always accepted.

module crc_framed_clocked_serial_sender_top #(
  parameter int unsigned MaxPayload = crcfss_pkg::MaxPayloadDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command_i,
  input  logic [7:0]                          payload_byte_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [crcfss_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [crcfss_pkg::RegW-1:0]         cfg_data_i,
  output logic                                strobe_o,
  output logic                                pin_select_o,
  output logic                                pin_level_o,
  output logic [crcfss_pkg::WaitW-1:0]        wait_before_o,
  output logic [crcfss_pkg::RegW-1:0]         wait_after_o,
  output logic                                frame_end_o
);

  localparam int unsigned AddrW    = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam logic [7:0]  MaxCount = 8'(MaxPayload);

  crcfss_pkg::ctrl_t ctrl;
  logic              need_fetch;

  logic [crcfss_pkg::RegW-1:0] regs_q [crcfss_pkg::NumRegs];
  logic [7:0]  count_q;
  logic [31:0] crc_q;
  logic        sending_q;
  logic [8:0]  idx_q;
  logic [4:0]  phase_q;
  logic [7:0]  pb_q;
  logic [7:0]  byte_q;
  logic [7:0]  rd_q;
  logic [7:0]  mem [MaxPayload];
  logic        strobe_q;

  logic                        sel_q, lvl_q, fe_q;
  logic [crcfss_pkg::WaitW-1:0] wb_q;
  logic [crcfss_pkg::RegW-1:0]  wa_q;

  logic                         sel_c, lvl_c;
  logic [crcfss_pkg::WaitW-1:0] wb_c;
  logic [4:0]                   phase_m2;
  logic [2:0]                   bit_k;
  logic                         last_phase, frame_done, emit_fire, load_ok;
  logic [8:0]                   idx_inc, total, idx_off;
  logic [AddrW-1:0]             rd_addr;
  logic [31:0]                  crc_out;
  logic [7:0]                   frame_byte;

  crcfss_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .command_i    (command_i),
    .need_fetch_i (need_fetch),
    .busy_o       (busy),
    .ctrl_o       (ctrl)
  );

  assign cfg_ready_o = 1'b1;

  assign emit_fire  = (ctrl.op == crcfss_pkg::OP_EMIT) && sending_q;
  assign need_fetch = emit_fire && (phase_q == 5'd0);
  assign load_ok    = (ctrl.op == crcfss_pkg::OP_LOAD) && !sending_q && (count_q < MaxCount);

  assign phase_m2   = phase_q - 5'd2;
  assign bit_k      = phase_m2[3:1];
  assign last_phase = (phase_q == crcfss_pkg::LastPhase);
  assign idx_inc    = idx_q + 9'd1;
  assign total      = crcfss_pkg::HeaderBytes + {1'b0, count_q};
  assign frame_done = last_phase && (idx_inc >= total);

  always_comb begin
    sel_c = 1'b0;
    lvl_c = 1'b0;
    wb_c  = '0;
    if (phase_q == 5'd0) begin
      lvl_c = 1'b1;
      wb_c  = (idx_q == 9'd0) ? '0 : {1'b0, regs_q[crcfss_pkg::RegByteGap]};
    end else if (phase_q == 5'd1) begin
      wb_c  = {1'b0, regs_q[crcfss_pkg::RegSyncHigh]};
    end else if (!phase_m2[0]) begin
      sel_c = 1'b1;
      lvl_c = byte_q[bit_k];
      wb_c  = (bit_k == 3'd0)
            ? ({1'b0, regs_q[crcfss_pkg::RegSyncGap]} + {1'b0, regs_q[crcfss_pkg::RegBitLead]})
            : {1'b0, regs_q[crcfss_pkg::RegBitLead]};
    end else begin
      lvl_c = ~bit_k[0];
      wb_c  = {1'b0, regs_q[crcfss_pkg::RegDataToClk]};
    end
  end

  assign crc_out = ~crc_q;
  assign idx_off = idx_q - crcfss_pkg::HeaderBytes;
  assign rd_addr = idx_off[AddrW-1:0];

  always_comb begin
    logic [8:0] crc_sel;
    crc_sel = idx_q - 9'd2;
    priority if (idx_q == 9'd0) begin
      frame_byte = crcfss_pkg::StartByte;
    end else if (idx_q == 9'd1) begin
      frame_byte = count_q;
    end else if (idx_q < crcfss_pkg::HeaderBytes) begin
      frame_byte = crc_out[{crc_sel[1:0], 3'b000} +: 8];
    end else begin
      frame_byte = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      mem[count_q[AddrW-1:0]] <= pb_q;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      pb_q <= payload_byte_i;
    end
    if (ctrl.op == crcfss_pkg::OP_FETCH) begin
      byte_q <= frame_byte;
    end
    if (emit_fire) begin
      sel_q <= sel_c;
      lvl_q <= lvl_c;
      wb_q  <= wb_c;
      fe_q  <= frame_done;
      wa_q  <= frame_done ? regs_q[crcfss_pkg::RegByteGap] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[crcfss_pkg::RegSyncHigh]  <= crcfss_pkg::SyncHighReset;
      regs_q[crcfss_pkg::RegSyncGap]   <= crcfss_pkg::SyncGapReset;
      regs_q[crcfss_pkg::RegBitLead]   <= crcfss_pkg::BitLeadReset;
      regs_q[crcfss_pkg::RegDataToClk] <= crcfss_pkg::DataToClkReset;
      regs_q[crcfss_pkg::RegByteGap]   <= crcfss_pkg::ByteGapReset;
      count_q   <= '0;
      crc_q     <= crcfss_pkg::CrcInit;
      sending_q <= 1'b0;
      idx_q     <= '0;
      phase_q   <= '0;
      strobe_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          crcfss_pkg::RegSyncHigh:  regs_q[crcfss_pkg::RegSyncHigh]  <= cfg_data_i;
          crcfss_pkg::RegSyncGap:   regs_q[crcfss_pkg::RegSyncGap]   <= cfg_data_i;
          crcfss_pkg::RegBitLead:   regs_q[crcfss_pkg::RegBitLead]   <= cfg_data_i;
          crcfss_pkg::RegDataToClk: regs_q[crcfss_pkg::RegDataToClk] <= cfg_data_i;
          crcfss_pkg::RegByteGap:   regs_q[crcfss_pkg::RegByteGap]   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      strobe_q <= emit_fire;
      if (load_ok) begin
        crc_q   <= crcfss_pkg::crc_add_byte(crc_q, pb_q);
        count_q <= count_q + 8'd1;
      end
      if ((ctrl.op == crcfss_pkg::OP_START) && !sending_q) begin
        sending_q <= 1'b1;
        idx_q     <= '0;
        phase_q   <= '0;
      end
      if (emit_fire) begin
        phase_q <= last_phase ? 5'd0 : (phase_q + 5'd1);
        if (last_phase) begin
          idx_q <= frame_done ? 9'd0 : idx_inc;
        end
        if (frame_done) begin
          sending_q <= 1'b0;
          count_q   <= '0;
          crc_q     <= crcfss_pkg::CrcInit;
        end
      end
    end
  end

  assign strobe_o      = strobe_q;
  assign pin_select_o  = sel_q;
  assign pin_level_o   = lvl_q;
  assign wait_before_o = wb_q;
  assign wait_after_o  = wa_q;
  assign frame_end_o   = fe_q;

`ifndef ASSERT_OFF
  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(ctrl.op == crcfss_pkg::OP_EMIT))
    else $error("result beat without a preceding emit step");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && fe_q) |-> (!sending_q && (count_q == 8'd0)))
    else $error("frame end did not clear the frame state");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < crcfss_pkg::PhasesPerByte)
    else $error("byte phase out of range");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending_q |-> (idx_q < total))
    else $error("frame byte index beyond the frame");

  a_fetch_after_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == crcfss_pkg::OP_FETCH) |-> $past(need_fetch))
    else $error("byte fetch without a sync write before it");
`endif

endmodule

>>> verif/crc_framed_clocked_serial_sender_top_tb.sv
// Self-checking testbench for crc_framed_clocked_serial_sender_top: a directed table, then
// random frames with noise commands, each pin write checked against an in-bench predictor.
// Depends on crcfss_pkg and the sender RTL only.
`timescale 1ns / 1ps

module crc_framed_clocked_serial_sender_top_tb;
  import crcfss_pkg::*;

  localparam logic [1:0] CmdReserved = 2'd3;
  localparam logic [RegW-1:0] RegMax = 20'hFFFFF;

  typedef struct packed {
    logic             sel;
    logic             lvl;
    logic [WaitW-1:0] wait_pre;
    logic [RegW-1:0]  wait_post;
    logic             last;
  } pin_write_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  pb;
    logic [15:0] reps;
    logic        typed;
    pin_write_t  want;
  } stim_row_t;

  localparam pin_write_t NoWrite = '0;

  // Typed rows hold writes that follow directly from the reset timing values.
  localparam stim_row_t DirectedRows [18] = '{
    '{CmdStart,    8'h00, 16'd1,   1'b0, NoWrite},
    '{CmdAdvance,  8'h00, 16'd1,   1'b1, '{1'b0, 1'b1, 21'd0, 20'd0, 1'b0}},
    '{CmdAdvance,  8'h00, 16'd1,   1'b1, '{1'b0, 1'b0, 21'd1000, 20'd0, 1'b0}},
    '{CmdAdvance,  8'h00, 16'd1,   1'b1, '{1'b1, 1'b0, 21'd104000, 20'd0, 1'b0}},
    '{CmdLoad,     8'hFF, 16'd1,   1'b0, NoWrite},
    '{CmdStart,    8'h00, 16'd1,   1'b0, NoWrite},
    '{CmdReserved, 8'h5A, 16'd1,   1'b0, NoWrite},
    '{CmdAdvance,  8'h00, 16'd104, 1'b0, NoWrite},
    '{CmdAdvance,  8'h00, 16'd1,   1'b1, '{1'b0, 1'b0, 21'd1000, 20'd10000, 1'b1}},
    '{CmdAdvance,  8'h00, 16'd1,   1'b0, NoWrite},
    '{CmdReserved, 8'hC3, 16'd1,   1'b0, NoWrite},
    '{CmdLoad,     8'h00, 16'd1,   1'b0, NoWrite},
    '{CmdLoad,     8'hFF, 16'd1,   1'b0, NoWrite},
    '{CmdLoad,     8'hA5, 16'd1,   1'b0, NoWrite},
    '{CmdStart,    8'h00, 16'd1,   1'b0, NoWrite},
    '{CmdAdvance,  8'h00, 16'd161, 1'b0, NoWrite},
    '{CmdAdvance,  8'h00, 16'd1,   1'b1, '{1'b0, 1'b0, 21'd1000, 20'd10000, 1'b1}},
    '{CmdAdvance,  8'hFF, 16'd1,   1'b0, NoWrite}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          command_i;
  logic [7:0]          payload_byte_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [RegW-1:0]     cfg_data_i;
  logic                strobe_o;
  logic                pin_select_o;
  logic                pin_level_o;
  logic [WaitW-1:0]    wait_before_o;
  logic [RegW-1:0]     wait_after_o;
  logic                frame_end_o;

  logic [RegW-1:0] timing_reg [NumRegs];
  logic [7:0]      payload_mem [256];
  logic [7:0]      payload_len;
  logic [31:0]     crc_run;
  logic            frame_busy;
  logic [8:0]      frame_pos;
  logic [4:0]      bit_slot;

  pin_write_t expected_writes [$];
  int         mismatches = 0;
  int         commands_sent = 0;
  int         idle_pct = 0;

  crc_framed_clocked_serial_sender_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .payload_byte_i (payload_byte_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .strobe_o       (strobe_o),
    .pin_select_o   (pin_select_o),
    .pin_level_o    (pin_level_o),
    .wait_before_o  (wait_before_o),
    .wait_after_o   (wait_after_o),
    .frame_end_o    (frame_end_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void predict_pin_write(input logic [1:0] cmd, input logic [7:0] pb);
    pin_write_t  w;
    logic [7:0]  cur;
    logic [31:0] crc_out;
    logic [8:0]  mem_pos;
    logic [4:0]  sub;
    logic [2:0]  bit_no;
    w = '0;
    case (cmd)
      CmdLoad: begin
        if (!frame_busy && payload_len < MaxPayloadDefault) begin
          payload_mem[payload_len] = pb;
          crc_run = crc_run ^ {24'd0, pb};
          for (int n = 0; n < 8; n++) begin
            crc_run = crc_run[0] ? ((crc_run >> 1) ^ CrcPoly) : (crc_run >> 1);
          end
          payload_len = payload_len + 8'd1;
        end
      end
      CmdStart: begin
        if (!frame_busy) begin
          frame_busy = 1'b1;
          frame_pos = '0;
          bit_slot = '0;
        end
      end
      CmdAdvance: begin
        if (frame_busy) begin
          crc_out = ~crc_run;
          mem_pos = frame_pos - HeaderBytes;
          case (frame_pos)
            9'd0: cur = StartByte;
            9'd1: cur = payload_len;
            9'd2, 9'd3, 9'd4, 9'd5: cur = crc_out[8*(frame_pos-9'd2) +: 8];
            default: cur = payload_mem[mem_pos[7:0]];
          endcase
          if (bit_slot == 5'd0) begin
            w.lvl = 1'b1;
            w.wait_pre = (frame_pos == 9'd0) ? '0 : {1'b0, timing_reg[RegByteGap]};
          end else if (bit_slot == 5'd1) begin
            w.wait_pre = {1'b0, timing_reg[RegSyncHigh]};
          end else begin
            sub = bit_slot - 5'd2;
            bit_no = sub[3:1];
            if (!sub[0]) begin
              w.sel = 1'b1;
              w.lvl = cur[bit_no];
              w.wait_pre = (bit_no == 3'd0) ?
                  {1'b0, timing_reg[RegSyncGap]} + {1'b0, timing_reg[RegBitLead]} :
                  {1'b0, timing_reg[RegBitLead]};
            end else begin
              w.lvl = ~bit_no[0];
              w.wait_pre = {1'b0, timing_reg[RegDataToClk]};
            end
          end
          bit_slot = bit_slot + 5'd1;
          if (bit_slot >= PhasesPerByte) begin
            bit_slot = '0;
            frame_pos = frame_pos + 9'd1;
            if (frame_pos >= HeaderBytes + {1'b0, payload_len}) begin
              w.last = 1'b1;
              w.wait_post = timing_reg[RegByteGap];
              frame_busy = 1'b0;
              frame_pos = '0;
              payload_len = '0;
              crc_run = CrcInit;
            end
          end
          expected_writes.push_back(w);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin : pin_write_check
    pin_write_t got;
    pin_write_t want;
    if (rst_ni && strobe_o !== 1'b0) begin
      got = {pin_select_o, pin_level_o, wait_before_o, wait_after_o, frame_end_o};
      if (expected_writes.size() == 0) begin
        $error("unexpected pin write: sel %0d level %0d", got.sel, got.lvl);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        if (got.sel !== want.sel) begin
          $error("pin_select: expected %0d, actual %0d", want.sel, got.sel);
          mismatches++;
        end
        if (got.lvl !== want.lvl) begin
          $error("pin_level: expected %0d, actual %0d", want.lvl, got.lvl);
          mismatches++;
        end
        if (got.wait_pre !== want.wait_pre) begin
          $error("wait_before: expected %0d, actual %0d", want.wait_pre, got.wait_pre);
          mismatches++;
        end
        if (got.wait_post !== want.wait_post) begin
          $error("wait_after: expected %0d, actual %0d", want.wait_post, got.wait_post);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("frame_end: expected %0d, actual %0d", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  task automatic issue(input logic [1:0] cmd, input logic [7:0] pb);
    @(negedge clk_i);
    while (busy !== 1'b0) @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    command_i = cmd;
    payload_byte_i = pb;
    @(posedge clk_i);
    predict_pin_write(cmd, pb);
    commands_sent++;
  endtask

  task automatic write_timing(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx < NumRegs) timing_reg[idx] = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Holds off new commands until every predicted write has been seen and the block is quiet.
  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy !== 1'b0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_timing(input int mode);
    logic [RegW-1:0] val;
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: val = RegMax;
        1: val = '0;
        default: val = RegW'($urandom_range(0, RegMax));
      endcase
      write_timing(i[CfgIdxW-1:0], val);
    end
  endtask

  task automatic run_frame(input int len, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(11) == 0) begin
        issue(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
      issue(CmdLoad, 8'($urandom_range(255)));
    end
    issue(CmdStart, 8'($urandom_range(255)));
    while (frame_busy) begin
      if (noisy && $urandom_range(9) == 0) issue(2'($urandom_range(3)), 8'($urandom_range(255)));
      else issue(CmdAdvance, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int goal;
    int len;
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = CmdLoad;
    payload_byte_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegSyncHigh;
    cfg_data_i = '0;
    timing_reg[RegSyncHigh] = SyncHighReset;
    timing_reg[RegSyncGap] = SyncGapReset;
    timing_reg[RegBitLead] = BitLeadReset;
    timing_reg[RegDataToClk] = DataToClkReset;
    timing_reg[RegByteGap] = ByteGapReset;
    payload_len = '0;
    crc_run = CrcInit;
    frame_busy = 1'b0;
    frame_pos = '0;
    bit_slot = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    idle_pct = 25;
    foreach (DirectedRows[r]) begin
      for (int n = 0; n < DirectedRows[r].reps; n++) begin
        issue(DirectedRows[r].cmd, DirectedRows[r].pb);
      end
      if (DirectedRows[r].typed) expected_writes[$] = DirectedRows[r].want;
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 25 : (ph == 1) ? 73 : 0;
      settle();
      program_timing(ph);
      goal = commands_sent + 250;
      while (commands_sent < goal) begin
        if (ph == 2 && $urandom_range(2) == 0) begin
          settle();
          program_timing(2);
        end
        len = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        run_frame(len, 1'b1);
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
